[rtl/gpad_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpad_pkg
// Shared types and constants for the classic-controller report decoder.
// ----------------------------------------------------------------------------
package gpad_pkg;

  localparam int unsigned NUM_AXES = 4;
  localparam int unsigned AXIS_W   = $clog2(NUM_AXES);
  localparam int unsigned RAW_W    = 6;
  localparam int unsigned SPAN_W   = 8;
  localparam int unsigned VAL_W    = 16;

  localparam int unsigned PADDR_W  = 3;
  localparam logic [0:0]  REG_BUTTON_MASK = 1'b0;
  localparam logic [15:0] BUTTON_MASK_RESET = 16'hFFFF;

  localparam logic REQ_DECODE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  report_byte0;
    logic [7:0]  report_byte1;
    logic [7:0]  report_byte2;
    logic [15:0] button_word;
  } req_t;

  typedef struct packed {
    logic [15:0]        buttons;
    logic signed [15:0] left_x_value;
    logic signed [15:0] left_y_value;
    logic signed [15:0] right_x_value;
    logic signed [15:0] right_y_value;
    logic [5:0]         left_x_raw;
    logic [5:0]         left_y_raw;
    logic [4:0]         right_x_raw;
    logic [4:0]         right_y_raw;
  } rsp_t;

endpackage

[rtl/gpad_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpad_div
// Restoring divider, one quotient bit per cycle, for num <= den spans.
// ----------------------------------------------------------------------------
module gpad_div import gpad_pkg::*; #(
  parameter int unsigned QW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SPAN_W-1:0] num,
  input  logic [SPAN_W-1:0] den,
  output logic              busy,
  output logic              done,
  output logic [QW-1:0]     quo
);

  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic [CNT_W-1:0]  cnt;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] den_q;
  logic              ge;
  logic [SPAN_W-1:0] diff;

  assign ge   = (rem >= den_q);
  assign diff = ge ? (rem - den_q) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(QW);
        rem   <= num;
        den_q <= den;
        quo   <= '0;
      end else if (busy) begin
        quo <= {quo[QW-2:0], ge};
        rem <= {diff[SPAN_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/gamepad_report_axis_autocal_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_report_axis_autocal_top
// Classic-controller report decoder with self-calibrating stick axes.
//
// A request transaction on req carries either a report to decode or a
// calibration clear. A decode yields one rsp transaction with the masked
// pressed buttons, the four raw axis readings and the four normalized
// axes in Q1.FRAC_BITS. A clear empties all axis calibration and yields
// nothing.
// A decode runs the four axes in turn through one shared restoring
// divider, one quotient bit per cycle; a centred axis skips the divide.
// req_ready is low while a decode runs and returns with rsp_valid, so
// a new request is not taken until the decode is through.
// rsp is held in an output register; a new request is accepted while it
// waits, and a finished decode holds until rsp is taken.
// Reset (rst, synchronous) marks every axis uncalibrated, drops any
// pending result and sets button_mask to all ones. The APB port holds
// button_mask at address 0; a decode uses the mask in force at acceptance.
// ----------------------------------------------------------------------------
module gamepad_report_axis_autocal_top import gpad_pkg::*; #(
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned PosLim = (FRAC_BITS < 15) ? (2**FRAC_BITS - 1) : 32767;
  localparam int unsigned NegLim = (FRAC_BITS < 15) ? (2**FRAC_BITS) : 32768;
  localparam logic [QW-1:0] POS_LIM = QW'(PosLim);
  localparam logic [QW-1:0] NEG_LIM = QW'(NegLim);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAL,
    S_DIV,
    S_OUT
  } state_t;

  state_t            state;
  logic [AXIS_W-1:0] axis;
  logic [15:0]       button_mask;
  logic [15:0]       buttons;

  logic              cal      [NUM_AXES];
  logic [SPAN_W-1:0] low_seen [NUM_AXES];
  logic [RAW_W-1:0]  centre   [NUM_AXES];
  logic [SPAN_W-1:0] high_seen[NUM_AXES];
  logic [RAW_W-1:0]  raw      [NUM_AXES];
  logic [VAL_W-1:0]  val      [NUM_AXES];
  logic              neg;

  // calibration update for the current axis
  logic              first;
  logic [SPAN_W-1:0] raw8;
  logic [SPAN_W-1:0] lo0, hi0, lo1, hi1;
  logic [RAW_W-1:0]  c0;
  logic              is_neg, is_eq;
  logic [SPAN_W-1:0] num;
  logic signed [SPAN_W:0] den;
  logic              skip;

  logic              div_start, div_busy, div_done;
  logic [QW-1:0]     div_quo;
  logic [QW-1:0]     mag_sat;
  logic [VAL_W-1:0]  div_val;
  logic              cfg_wr;

  always_comb begin
    first  = !cal[axis];
    raw8   = SPAN_W'(raw[axis]);
    c0     = first ? raw[axis] : centre[axis];
    lo0    = first ? (raw8 - SPAN_W'(2)) : low_seen[axis];
    hi0    = first ? (raw8 + SPAN_W'(2)) : high_seen[axis];
    lo1    = (raw8 < lo0) ? raw8 : lo0;
    hi1    = (raw8 > hi0) ? raw8 : hi0;
    is_neg = (raw[axis] < c0);
    is_eq  = (raw[axis] == c0);
    num    = is_neg ? SPAN_W'(c0 - raw[axis]) : SPAN_W'(raw[axis] - c0);
    den    = is_neg ? ($signed({1'b0, SPAN_W'(c0)}) - $signed({1'b0, lo1}))
                    : ($signed({1'b0, hi1}) - $signed({1'b0, SPAN_W'(c0)}));
    skip   = is_eq || (den <= 0);
  end

  assign div_start = (state == S_CAL) && !skip;

  gpad_div #(
    .QW (QW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den[SPAN_W-1:0]),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    if (neg) begin
      mag_sat = (div_quo > NEG_LIM) ? NEG_LIM : div_quo;
      div_val = VAL_W'(17'd0 - 17'(mag_sat));
    end else begin
      mag_sat = (div_quo > POS_LIM) ? POS_LIM : div_quo;
      div_val = VAL_W'(mag_sat);
    end
  end

  assign req_ready = (state == S_IDLE);
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_BUTTON_MASK);
  assign prdata    = (paddr[2] == REG_BUTTON_MASK) ? {16'd0, button_mask} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      axis        <= '0;
      rsp_valid   <= 1'b0;
      button_mask <= BUTTON_MASK_RESET;
      for (int i = 0; i < NUM_AXES; i++) begin
        cal[i] <= 1'b0;
      end
    end else begin
      if (cfg_wr) begin
        button_mask <= pwdata[15:0];
      end
      if (rsp_valid && rsp_ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.req_type == REQ_CLEAR) begin
              for (int i = 0; i < NUM_AXES; i++) begin
                cal[i] <= 1'b0;
              end
            end else begin
              buttons <= ~req.button_word & button_mask;
              raw[0]  <= req.report_byte0[5:0];
              raw[1]  <= req.report_byte1[5:0];
              raw[2]  <= {1'b0, req.report_byte0[7:6], req.report_byte1[7:6],
                          req.report_byte2[7]};
              raw[3]  <= {1'b0, req.report_byte2[4:0]};
              axis    <= '0;
              state   <= S_CAL;
            end
          end
        end
        S_CAL: begin
          cal[axis]       <= 1'b1;
          centre[axis]    <= c0;
          low_seen[axis]  <= lo1;
          high_seen[axis] <= hi1;
          neg             <= is_neg;
          if (skip) begin
            val[axis] <= '0;
            axis      <= axis + 1'b1;
            state     <= (axis == AXIS_W'(NUM_AXES - 1)) ? S_OUT : S_CAL;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            val[axis] <= div_val;
            axis      <= axis + 1'b1;
            state     <= (axis == AXIS_W'(NUM_AXES - 1)) ? S_OUT : S_CAL;
          end
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.buttons       <= buttons;
            rsp.left_x_value  <= val[0];
            rsp.left_y_value  <= val[1];
            rsp.right_x_value <= val[2];
            rsp.right_y_value <= val[3];
            rsp.left_x_raw    <= raw[0];
            rsp.left_y_raw    <= raw[1];
            rsp.right_x_raw   <= raw[2][4:0];
            rsp.right_y_raw   <= raw[3][4:0];
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !div_busy)
    else $error("divider busy while accepting requests");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider result outside divide state");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req.req_type == REQ_CLEAR))
      |=> (!cal[0] && !cal[1] && !cal[2] && !cal[3]))
    else $error("calibration not cleared");

  a_cal_marks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CAL) |=> cal[$past(axis)])
    else $error("axis not marked calibrated");

endmodule
